/* rtl/core/ffha_pkg.sv */
// Shared constants, types and codes for the first-fit heap allocator.
package ffha_pkg;

   localparam int unsigned HEAP_BYTES   = 33554432;
   localparam int unsigned MAX_BLOCKS   = 64;
   localparam int unsigned HEADER_BYTES = 16;

   localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
   localparam int unsigned CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int unsigned OFS_W  = $clog2(HEAP_BYTES);
   localparam int unsigned SIZE_W = 27;
   localparam int unsigned ENTRY_W = 2 * OFS_W + 1;

   localparam logic [31:0] FLOOR_MIN  = 32'h00C0_0000;
   localparam logic [32:0] PAGE_ROUND = 33'h0_0000_0FFF;
   localparam logic [32:0] PAGE_MASK  = 33'h1_FFFF_F000;

   localparam logic [OFS_W-1:0] HDR      = OFS_W'(HEADER_BYTES);
   localparam logic [OFS_W-1:0] INIT_PAY = OFS_W'(HEAP_BYTES - HEADER_BYTES);

   localparam logic REG_HEAP_FLOOR = 1'b0;

   typedef struct packed {
      logic [OFS_W-1:0] start;
      logic [OFS_W-1:0] payload;
      logic             free;
   } entry_type;

   typedef enum logic [1:0] {OP_ALLOC, OP_FREE, OP_STATS, OP_RSVD} opcode_type;
   typedef enum logic [1:0] {STAT_OK, STAT_FAIL, STAT_IGN} status_type;
   typedef enum logic [1:0] {RD_I, RD_I1, RD_JM1, RD_JR} rd_sel_type;
   typedef enum logic [2:0] {
      WR_INIT, WR_USED_FULL, WR_USED_SIZE, WR_SPLIT_HI, WR_MERGE, WR_SHIFT
   } wr_sel_type;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_CHK, ST_RD, ST_EV, ST_END, ST_USE, ST_SUR, ST_SUW,
      ST_SPH, ST_SPL, ST_RDN, ST_EVN, ST_MRG, ST_SDR, ST_SDW
   } state_type;

   typedef struct packed {
      logic       latch_req;
      logic       inc_i;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       cap_hit;
      logic       save_prev;
      logic       accum;
      logic       cap_succ;
      logic       j_load_cnt;
      logic       j_load_lo;
      logic       j_dec;
      logic       j_inc;
      logic       cnt_init;
      logic       cnt_inc;
      logic       cnt_sub;
      logic       set_status;
      status_type status_val;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       zero_size;
      logic       zero_addr;
      logic       scan_end;
      logic       fit;
      logic       split;
      logic       match;
      logic       cur_free;
      logic       up_more;
      logic       dn_more;
      logic       out_free;
   } sts_type;

endpackage

/* rtl/core/ffha_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/core/ffha_ctrl.sv */
// Sequencer for table scans, splits, merges and result hand-off.
module ffha_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             cfg_wr,
   input  logic             req_tvalid,
   input  ffha_pkg::sts_type sts,
   output logic             req_tready,
   output ffha_pkg::cmd_type cmd
);
   import ffha_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: state_in = ST_IDLE;
         ST_IDLE: if (req_tvalid) state_in = ST_CHK;
         ST_CHK: begin
            if (sts.op == OP_RSVD || (sts.op == OP_ALLOC && sts.zero_size) ||
                (sts.op == OP_FREE && sts.zero_addr)) begin
               state_in = ST_END;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_RD: state_in = sts.scan_end ? ST_END : ST_EV;
         ST_EV: begin
            case (sts.op)
               OP_ALLOC: begin
                  if (sts.fit) state_in = sts.split ? ST_SUR : ST_USE;
                  else state_in = ST_RD;
               end
               OP_FREE: begin
                  if (sts.match) state_in = sts.cur_free ? ST_END : ST_RDN;
                  else state_in = ST_RD;
               end
               default: state_in = ST_RD;
            endcase
         end
         ST_END: if (sts.out_free) state_in = ST_IDLE;
         ST_USE: state_in = ST_END;
         ST_SUR: state_in = sts.up_more ? ST_SUW : ST_SPH;
         ST_SUW: state_in = ST_SUR;
         ST_SPH: state_in = ST_SPL;
         ST_SPL: state_in = ST_END;
         ST_RDN: state_in = ST_EVN;
         ST_EVN: state_in = ST_MRG;
         ST_MRG: state_in = ST_SDR;
         ST_SDR: state_in = sts.dn_more ? ST_SDW : ST_END;
         ST_SDW: state_in = ST_SDR;
         default: state_in = ST_INIT;
      endcase
      if (cfg_wr) begin
         state_in = ST_INIT;
      end
   end

   always_comb begin
      cmd = '0;
      cmd.rd_sel = RD_I;
      cmd.wr_sel = WR_SHIFT;
      cmd.status_val = STAT_OK;
      req_tready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.wr_en = 1'b1;
            cmd.wr_sel = WR_INIT;
            cmd.cnt_init = 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.latch_req = req_tvalid;
         end
         ST_CHK: begin
            cmd.set_status = 1'b1;
            cmd.status_val = (sts.op == OP_ALLOC) ? STAT_FAIL : STAT_IGN;
         end
         ST_RD: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = RD_I;
            if (sts.scan_end) begin
               cmd.set_status = 1'b1;
               case (sts.op)
                  OP_ALLOC: cmd.status_val = STAT_FAIL;
                  OP_FREE:  cmd.status_val = STAT_IGN;
                  default:  cmd.status_val = STAT_OK;
               endcase
            end
         end
         ST_EV: begin
            case (sts.op)
               OP_ALLOC: begin
                  cmd.cap_hit = sts.fit;
                  cmd.j_load_cnt = sts.fit && sts.split;
                  cmd.inc_i = !sts.fit;
               end
               OP_FREE: begin
                  cmd.cap_hit = sts.match && !sts.cur_free;
                  cmd.save_prev = !sts.match;
                  cmd.inc_i = !sts.match;
               end
               default: begin
                  cmd.accum = 1'b1;
                  cmd.inc_i = 1'b1;
               end
            endcase
         end
         ST_END: cmd.out_load = sts.out_free;
         ST_USE: begin
            cmd.wr_en = 1'b1;
            cmd.wr_sel = WR_USED_FULL;
            cmd.set_status = 1'b1;
         end
         ST_SUR: begin
            cmd.rd_en = sts.up_more;
            cmd.rd_sel = RD_JM1;
         end
         ST_SUW: begin
            cmd.wr_en = 1'b1;
            cmd.j_dec = 1'b1;
         end
         ST_SPH: begin
            cmd.wr_en = 1'b1;
            cmd.wr_sel = WR_SPLIT_HI;
         end
         ST_SPL: begin
            cmd.wr_en = 1'b1;
            cmd.wr_sel = WR_USED_SIZE;
            cmd.cnt_inc = 1'b1;
            cmd.set_status = 1'b1;
         end
         ST_RDN: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = RD_I1;
         end
         ST_EVN: cmd.cap_succ = 1'b1;
         ST_MRG: begin
            cmd.wr_en = 1'b1;
            cmd.wr_sel = WR_MERGE;
            cmd.j_load_lo = 1'b1;
         end
         ST_SDR: begin
            cmd.rd_en = sts.dn_more;
            cmd.rd_sel = RD_JR;
            cmd.cnt_sub = !sts.dn_more;
            cmd.set_status = !sts.dn_more;
         end
         ST_SDW: begin
            cmd.wr_en = 1'b1;
            cmd.j_inc = 1'b1;
         end
         default: cmd = '0;
      endcase
   end
endmodule

/* rtl/core/ffha_dp.sv */
// Block table, scan registers, heap base and result register.
module ffha_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  ffha_pkg::cmd_type           cmd,
   output ffha_pkg::sts_type           sts,
   input  logic                        cfg_wr,
   input  logic [31:0]                 cfg_data,
   output logic [31:0]                 heap_floor,
   input  logic [1:0]                  req_op,
   input  logic [25:0]                 req_size,
   input  logic [31:0]                 req_addr,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [31:0]                 rsp_address,
   output logic [6:0]                  rsp_blocks,
   output logic [6:0]                  rsp_fblk_cnt,
   output logic [25:0]                 rsp_fbyte_sum,
   output logic [25:0]                 rsp_ubyte_sum
);
   import ffha_pkg::*;

   logic [31:0] floor_ff, base_ff;
   logic [32:0] base_max, base_rnd;
   opcode_type  op_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [31:0] addr_ff;
   logic [CNT_W-1:0] i_ff, j_ff, cnt_ff;
   logic [CNT_W-1:0] i_p1, lo;
   entry_type cur, wdata;
   logic [ENTRY_W-1:0] rdata;
   logic [IDX_W-1:0] raddr, waddr;
   logic [OFS_W-1:0] hit_start_ff, hit_pay_ff, prev_start_ff, prev_pay_ff, succ_pay_ff;
   logic prev_free_ff, pred_ff, succ_ff;
   logic [1:0] r;
   logic [OFS_W-1:0] merged;
   logic [31:0] cur_addr;
   logic [6:0]  acc_cnt_ff, acc_fcnt_ff;
   logic [25:0] acc_fb_ff, acc_ub_ff;
   logic [31:0] res_addr_ff;
   status_type  res_status_ff;
   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_address_ff;
   logic [6:0]  rsp_blocks_ff, rsp_fblk_cnt_ff;
   logic [25:0] rsp_fbyte_sum_ff, rsp_ubyte_sum_ff;

   assign base_max = (cfg_data > FLOOR_MIN) ? {1'b0, cfg_data} : {1'b0, FLOOR_MIN};
   assign base_rnd = (base_max + PAGE_ROUND) & PAGE_MASK;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= FLOOR_MIN;
         base_ff  <= FLOOR_MIN;
      end else if (cfg_wr) begin
         floor_ff <= cfg_data;
         base_ff  <= base_rnd[31:0];
      end
   end
   assign heap_floor = floor_ff;

   assign cur = entry_type'(rdata);
   assign i_p1 = i_ff + CNT_W'(1);
   assign r = {1'b0, pred_ff} + {1'b0, succ_ff};
   assign lo = pred_ff ? (i_ff - CNT_W'(1)) : i_ff;
   assign merged = (pred_ff ? (prev_pay_ff + HDR) : '0) + hit_pay_ff +
                   (succ_ff ? (succ_pay_ff + HDR) : '0);
   assign cur_addr = base_ff + 32'(cur.start) + 32'(HEADER_BYTES);

   always_comb begin
      case (cmd.rd_sel)
         RD_I:   raddr = i_ff[IDX_W-1:0];
         RD_I1:  raddr = i_p1[IDX_W-1:0];
         RD_JM1: raddr = IDX_W'(j_ff - CNT_W'(1));
         RD_JR:  raddr = IDX_W'(j_ff + CNT_W'(r));
         default: raddr = '0;
      endcase
   end

   always_comb begin
      waddr = j_ff[IDX_W-1:0];
      wdata = cur;
      case (cmd.wr_sel)
         WR_INIT: begin
            waddr = '0;
            wdata = '{start: '0, payload: INIT_PAY, free: 1'b1};
         end
         WR_USED_FULL: begin
            waddr = i_ff[IDX_W-1:0];
            wdata = '{start: hit_start_ff, payload: hit_pay_ff, free: 1'b0};
         end
         WR_USED_SIZE: begin
            waddr = i_ff[IDX_W-1:0];
            wdata = '{start: hit_start_ff, payload: size_ff[OFS_W-1:0], free: 1'b0};
         end
         WR_SPLIT_HI: begin
            waddr = i_p1[IDX_W-1:0];
            wdata = '{start: hit_start_ff + HDR + size_ff[OFS_W-1:0],
                      payload: hit_pay_ff - size_ff[OFS_W-1:0] - HDR, free: 1'b1};
         end
         WR_MERGE: begin
            waddr = lo[IDX_W-1:0];
            wdata = '{start: pred_ff ? prev_start_ff : hit_start_ff,
                      payload: merged, free: 1'b1};
         end
         WR_SHIFT: begin
            waddr = j_ff[IDX_W-1:0];
            wdata = cur;
         end
         default: wdata = cur;
      endcase
   end

   ffha_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_table (
      .clock  (clock),
      .wr_en  (cmd.wr_en),
      .wr_addr(waddr),
      .wr_data(wdata),
      .rd_en  (cmd.rd_en),
      .rd_addr(raddr),
      .rd_data(rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff   <= opcode_type'(req_op);
         size_ff <= ({1'b0, req_size} + SIZE_W'(3)) & ~SIZE_W'(3);
         addr_ff <= req_addr;
      end
      if (cmd.save_prev) begin
         prev_start_ff <= cur.start;
         prev_pay_ff   <= cur.payload;
         prev_free_ff  <= cur.free;
      end
      if (cmd.cap_hit) begin
         hit_start_ff <= cur.start;
         hit_pay_ff   <= cur.payload;
         pred_ff      <= prev_free_ff && (i_ff != '0);
      end
      if (cmd.cap_succ) begin
         succ_pay_ff <= cur.payload;
         succ_ff     <= (i_p1 < cnt_ff) && cur.free;
      end
      if (cmd.latch_req) begin
         i_ff <= '0;
      end else if (cmd.inc_i) begin
         i_ff <= i_p1;
      end
      if (cmd.j_load_cnt) begin
         j_ff <= cnt_ff;
      end else if (cmd.j_load_lo) begin
         j_ff <= lo + CNT_W'(1);
      end else if (cmd.j_dec) begin
         j_ff <= j_ff - CNT_W'(1);
      end else if (cmd.j_inc) begin
         j_ff <= j_ff + CNT_W'(1);
      end
      if (cmd.latch_req) begin
         res_addr_ff <= '0;
      end else if (cmd.cap_hit && op_ff == OP_ALLOC) begin
         res_addr_ff <= cur_addr;
      end
      if (cmd.set_status) begin
         res_status_ff <= cmd.status_val;
      end
      if (cmd.latch_req) begin
         acc_cnt_ff  <= '0;
         acc_fcnt_ff <= '0;
         acc_fb_ff   <= '0;
         acc_ub_ff   <= '0;
      end else if (cmd.accum) begin
         acc_cnt_ff <= acc_cnt_ff + 7'd1;
         if (cur.free) begin
            acc_fcnt_ff <= acc_fcnt_ff + 7'd1;
            acc_fb_ff   <= acc_fb_ff + 26'(cur.payload);
         end else begin
            acc_ub_ff <= acc_ub_ff + 26'(cur.payload);
         end
      end
      if (cmd.out_load) begin
         rsp_status_ff    <= res_status_ff;
         rsp_address_ff   <= res_addr_ff;
         rsp_blocks_ff    <= acc_cnt_ff;
         rsp_fblk_cnt_ff  <= acc_fcnt_ff;
         rsp_fbyte_sum_ff <= acc_fb_ff;
         rsp_ubyte_sum_ff <= acc_ub_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.cnt_init) begin
            cnt_ff <= CNT_W'(1);
         end else if (cmd.cnt_inc) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else if (cmd.cnt_sub) begin
            cnt_ff <= cnt_ff - CNT_W'(r);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      sts.op        = op_ff;
      sts.zero_size = (size_ff == '0);
      sts.zero_addr = (addr_ff == '0);
      sts.scan_end  = (i_ff >= cnt_ff);
      sts.fit       = cur.free && ({2'b0, cur.payload} >= size_ff);
      sts.split     = ({3'b0, cur.payload} >= ({1'b0, size_ff} + (SIZE_W + 1)'(HEADER_BYTES + 4)))
                      && (cnt_ff < CNT_W'(MAX_BLOCKS));
      sts.match     = (cur_addr == addr_ff);
      sts.cur_free  = cur.free;
      sts.up_more   = (j_ff > i_p1);
      sts.dn_more   = (r != 2'd0) && ((j_ff + CNT_W'(r)) < cnt_ff);
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_address   = rsp_address_ff;
   assign rsp_blocks    = rsp_blocks_ff;
   assign rsp_fblk_cnt  = rsp_fblk_cnt_ff;
   assign rsp_fbyte_sum = rsp_fbyte_sum_ff;
   assign rsp_ubyte_sum = rsp_ubyte_sum_ff;

   a_split_room: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> cnt_ff < CNT_W'(MAX_BLOCKS))
      else $error("split with full table");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && res_status_ff != STAT_OK) |=> rsp_address_ff == '0)
      else $error("failed request carries an address");
   a_merge_keep: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_sub |-> cnt_ff > CNT_W'(r))
      else $error("merge empties the table");
endmodule

/* rtl/core/first_fit_heap_allocator.sv */
// Top level of the first-fit heap allocator with block coalescing.
// One request is handled at a time. The block table (up to MAX_BLOCKS entries) sits in a
// single-port-read RAM and every table step is a read state followed by an evaluate state,
// walking the entries until a fit, a match or the table end; a split adds a read and a write
// state per entry moved up, a merge a read and a write state per entry moved down.
// After reset and after each heap_floor write the table is rebuilt as one free block. Results
// wait in an output register; the next request is taken once the block is back in idle.
module first_fit_heap_allocator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,  // request_size[25:0], address[57:26], zero pad
   input  logic [1:0]   req_tuser,  // opcode[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,  // result_address[31:0], block_count[38:32],
                                    // free_block_count[45:39], free_byte_total[71:46],
                                    // used_byte_total[97:72], zero pad
   output logic [1:0]   rsp_tuser,  // status[1:0]
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);
   import ffha_pkg::*;

   cmd_type     cmd;
   sts_type     sts;
   logic        cfg_wr;
   logic [31:0] heap_floor;
   logic [1:0]  status;
   logic [31:0] result_address;
   logic [6:0]  block_count, free_block_count;
   logic [25:0] free_byte_total, used_byte_total;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_HEAP_FLOOR);
   assign prdata = (paddr[2] == REG_HEAP_FLOOR) ? heap_floor : '0;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg_wr    (cfg_wr),
      .req_tvalid(req_tvalid),
      .sts       (sts),
      .req_tready(req_tready),
      .cmd       (cmd)
   );

   ffha_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .cfg_wr       (cfg_wr),
      .cfg_data     (pwdata),
      .heap_floor   (heap_floor),
      .req_op       (req_tuser),
      .req_size     (req_tdata[25:0]),
      .req_addr     (req_tdata[57:26]),
      .rsp_ready    (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_status   (status),
      .rsp_address  (result_address),
      .rsp_blocks   (block_count),
      .rsp_fblk_cnt (free_block_count),
      .rsp_fbyte_sum(free_byte_total),
      .rsp_ubyte_sum(used_byte_total)
   );

   assign rsp_tuser = status;
   assign rsp_tdata = {6'b0, used_byte_total, free_byte_total, free_block_count,
                       block_count, result_address};
endmodule
